### rtl/ohr_pkg.sv
// shared types and constants for the heading ruler raster unit
// no dependencies; imported by every module of the block except ohr_div
package ohr_pkg;

    localparam int CFG_W      = 12;
    localparam int PARTS_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int PIX_W      = 8;
    localparam int DATA_IN_W  = 8;

    localparam int MAX_DIM_DEF   = 2048;
    localparam int BAND_HALF_DEF = 2;

    localparam logic [PIX_W-1:0]   PIX_ON        = 8'hFF;
    localparam logic [PIX_W-1:0]   PIX_OFF       = 8'h00;
    localparam logic [PARTS_W-1:0] DEFAULT_PARTS = 8'd2;

    // register values after reset
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam int RST_RULER_WIDTH  = 256;
    localparam int RST_RULER_HEIGHT = 32;
    localparam int RST_PART_COUNT   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_RULER_WIDTH  = 3'd2,
        CFG_RULER_HEIGHT = 3'd3,
        CFG_PART_COUNT   = 3'd4
    } ohr_cfg_idx_t;

    // control from the config block to the raster block
    typedef struct packed {
        logic busy;      // spacing being recomputed, counters held at frame start
        logic ticks_en;  // division ticks are drawn
    } ohr_ctrl_t;

endpackage

### rtl/osd_heading_ruler_raster_unit.sv
// top level of the heading ruler overlay raster generator
// registered output: m_axis_tvalid rises the cycle after an input transaction; one pixel per
// cycle unless busy or stalled by m_axis_tready; a known register write holds s_axis_tready
// low for the iterative spacing divider (one quotient bit per cycle), then restarts a frame
// reset (rst_n, async, active low): registers take their reset values, spacing is preset,
// counters point at row 0 column 0, no output pending
module osd_heading_ruler_raster_unit #(
    parameter int MAX_DIM   = ohr_pkg::MAX_DIM_DEF,    // largest ruler dimension
    parameter int BAND_HALF = ohr_pkg::BAND_HALF_DEF   // half width of drawn bands
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // pixel tick input, one transaction per pixel
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ohr_pkg::DATA_IN_W-1:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    // pixel output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ohr_pkg::PIX_W-1:0]      m_axis_tdata,   // [7:0] pixel_value
    output logic                           m_axis_tlast,   // last_in_frame
    output logic                           m_axis_tuser,   // [0] last_in_row
    // register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ohr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ohr_pkg::CFG_W-1:0]      cfg_data
);

    import ohr_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SP_W  = $clog2(MAX_DIM / 2 + 1);

    // clamped dimensions and tick spacing, all registered in the config block
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [SP_W-1:0]  spacing;
    ohr_ctrl_t        ctrl;

    // registers, clamp and spacing divider; busy holds off pixel transactions
    ohr_cfg #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .SP_W    (SP_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .width     (width),
        .height    (height),
        .spacing   (spacing),
        .ctrl      (ctrl)
    );

    // counters and pixel rules; output register parts input and output handshakes
    ohr_raster #(
        .MAX_DIM   (MAX_DIM),
        .BAND_HALF (BAND_HALF),
        .DIM_W     (DIM_W),
        .SP_W      (SP_W)
    ) u_raster (
        .clk           (clk),
        .rst_n         (rst_n),
        .width         (width),
        .height        (height),
        .spacing       (spacing),
        .ctrl          (ctrl),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .restart       (s_axis_tdata[0]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .pixel_value   (m_axis_tdata),
        .last_in_row   (m_axis_tuser),
        .last_in_frame (m_axis_tlast)
    );

endmodule

### rtl/ohr_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module ohr_div #(
    parameter int DVD_W = 11,
    parameter int DVS_W = 8,
    parameter logic [DVD_W-1:0] RST_Q = '0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= RST_Q;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            cnt_reg  <= CNT_W'(DVD_W);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            quo_reg  <= {quo_reg[DVD_W-2:0], ge};
            rem_reg  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/ohr_cfg.sv
// configuration registers, dimension clamping and tick spacing derivation
// depends on ohr_pkg and ohr_div
module ohr_cfg #(
    parameter int MAX_DIM = ohr_pkg::MAX_DIM_DEF,
    parameter int DIM_W   = $clog2(MAX_DIM + 1),
    parameter int SP_W    = $clog2(MAX_DIM / 2 + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ohr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ohr_pkg::CFG_W-1:0]      cfg_data,
    output logic [DIM_W-1:0]               width,
    output logic [DIM_W-1:0]               height,
    output logic [SP_W-1:0]                spacing,
    output ohr_pkg::ohr_ctrl_t             ctrl
);

    import ohr_pkg::*;

    localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int RST_MIN_W = (RST_RULER_WIDTH < RST_IMAGE_WIDTH) ?
                               RST_RULER_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_MIN_H = (RST_RULER_HEIGHT < RST_IMAGE_HEIGHT) ?
                               RST_RULER_HEIGHT : RST_IMAGE_HEIGHT;
    localparam int RST_W = (RST_MIN_W < MAX_DIM) ? RST_MIN_W : MAX_DIM;
    localparam int RST_H = (RST_MIN_H < MAX_DIM) ? RST_MIN_H : MAX_DIM;
    localparam int RST_SPACING = (RST_W / 2) / RST_PART_COUNT;

    logic [CFG_W-1:0]   img_w_reg;
    logic [CFG_W-1:0]   img_h_reg;
    logic [CFG_W-1:0]   rul_w_reg;
    logic [CFG_W-1:0]   rul_h_reg;
    logic [PARTS_W-1:0] parts_reg;
    logic [DIM_W-1:0]   w_reg;
    logic [DIM_W-1:0]   h_reg;
    logic [1:0]         start_pipe_reg;

    logic [DIM_W-1:0]   w_next;
    logic [DIM_W-1:0]   h_next;
    logic [CFG_W-1:0]   min_w;
    logic [CFG_W-1:0]   min_h;
    logic [CMP_W-1:0]   cmp_w;
    logic [CMP_W-1:0]   cmp_h;
    logic               wr_take;
    logic               wr_known;
    logic [PARTS_W-1:0] parts_eff;
    logic               div_busy;
    logic               busy;

    assign wr_take = cfg_valid && cfg_ready;

    always_comb
    begin
        min_w  = (rul_w_reg < img_w_reg) ? rul_w_reg : img_w_reg;
        min_h  = (rul_h_reg < img_h_reg) ? rul_h_reg : img_h_reg;
        cmp_w  = CMP_W'(min_w);
        cmp_h  = CMP_W'(min_h);
        w_next = (cmp_w < CMP_W'(MAX_DIM)) ? DIM_W'(cmp_w) : DIM_W'(MAX_DIM);
        h_next = (cmp_h < CMP_W'(MAX_DIM)) ? DIM_W'(cmp_h) : DIM_W'(MAX_DIM);
        parts_eff = (parts_reg == '0) ? DEFAULT_PARTS : parts_reg;
    end

    always_comb
    begin
        unique case (ohr_cfg_idx_t'(cfg_index))
            CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_RULER_WIDTH,
            CFG_RULER_HEIGHT, CFG_PART_COUNT: wr_known = 1'b1;
            default:                          wr_known = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg      <= CFG_W'(RST_IMAGE_WIDTH);
            img_h_reg      <= CFG_W'(RST_IMAGE_HEIGHT);
            rul_w_reg      <= CFG_W'(RST_RULER_WIDTH);
            rul_h_reg      <= CFG_W'(RST_RULER_HEIGHT);
            parts_reg      <= PARTS_W'(RST_PART_COUNT);
            w_reg          <= DIM_W'(RST_W);
            h_reg          <= DIM_W'(RST_H);
            start_pipe_reg <= '0;
        end
        else
        begin
            w_reg          <= w_next;
            h_reg          <= h_next;
            // divider starts once the clamped width has settled
            start_pipe_reg <= {start_pipe_reg[0], wr_take && wr_known};
            if (wr_take)
            begin
                unique case (ohr_cfg_idx_t'(cfg_index))
                    CFG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                    CFG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                    CFG_RULER_WIDTH:  rul_w_reg <= cfg_data;
                    CFG_RULER_HEIGHT: rul_h_reg <= cfg_data;
                    CFG_PART_COUNT:   parts_reg <= cfg_data[PARTS_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    ohr_div #(
        .DVD_W (SP_W),
        .DVS_W (PARTS_W),
        .RST_Q (SP_W'(RST_SPACING))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_pipe_reg[1]),
        .dividend (SP_W'(w_reg >> 1)),
        .divisor  (parts_eff),
        .busy     (div_busy),
        .quotient (spacing)
    );

    assign busy          = (start_pipe_reg != '0) || div_busy;
    assign cfg_ready     = !busy;
    assign width         = w_reg;
    assign height        = h_reg;
    assign ctrl.busy     = busy;
    assign ctrl.ticks_en = (parts_reg != PARTS_W'(1)) && (spacing != '0);

endmodule

### rtl/ohr_raster.sv
// raster counters, pixel rule evaluation and output register
// depends on ohr_pkg
module ohr_raster #(
    parameter int MAX_DIM   = ohr_pkg::MAX_DIM_DEF,
    parameter int BAND_HALF = ohr_pkg::BAND_HALF_DEF,
    parameter int DIM_W     = $clog2(MAX_DIM + 1),
    parameter int SP_W      = $clog2(MAX_DIM / 2 + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [DIM_W-1:0]              width,
    input  logic [DIM_W-1:0]              height,
    input  logic [SP_W-1:0]               spacing,
    input  ohr_pkg::ohr_ctrl_t            ctrl,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic                          restart,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ohr_pkg::PIX_W-1:0]     pixel_value,
    output logic                          last_in_row,
    output logic                          last_in_frame
);

    import ohr_pkg::*;

    localparam int COL_W = $clog2(MAX_DIM);
    localparam int SUM_W = DIM_W + 2;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] row_reg;
    logic [SP_W-1:0]  phase_reg;
    logic             m_valid_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             eor_reg;
    logic             eof_reg;

    logic             take;
    logic             empty;
    logic             wrap;
    logic [COL_W-1:0] c;
    logic [COL_W-1:0] r;
    logic [SP_W-1:0]  ph;
    logic [SUM_W-1:0] cs;
    logic [SUM_W-1:0] rs;
    logic [SUM_W-1:0] ws;
    logic [SUM_W-1:0] hs;
    logic [SUM_W-1:0] half;
    logic             side_on;
    logic             bottom_on;
    logic             center_on;
    logic             tick_here;
    logic             tick_left;
    logic             tick_right;
    logic             on;
    logic             eor;
    logic             eof;
    logic [SP_W:0]    ph_inc;

    assign s_axis_tready = !ctrl.busy && (!m_valid_reg || m_axis_tready);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign empty         = (width == '0) || (height == '0);

    always_comb
    begin
        wrap = restart || (SUM_W'(col_reg) >= SUM_W'(width))
                       || (SUM_W'(row_reg) >= SUM_W'(height));
        c    = wrap ? '0 : col_reg;
        r    = wrap ? '0 : row_reg;
        ph   = wrap ? '0 : phase_reg;
        cs   = SUM_W'(c);
        rs   = SUM_W'(r);
        ws   = SUM_W'(width);
        hs   = SUM_W'(height);
        half = ws >> 1;

        // outer columns and bottom rows
        side_on   = (cs + SUM_W'(BAND_HALF + 1) >= ws) || (cs <= SUM_W'(BAND_HALF));
        bottom_on = (rs + SUM_W'(BAND_HALF + 1) >= hs);
        // band around the center column half-1
        center_on = (cs + SUM_W'(BAND_HALF + 2) >= half) &&
                    (cs <= half + SUM_W'(BAND_HALF));
        // a tick covers its own column and one either side
        tick_here  = (ph == '0) && (c != '0) && (cs + SUM_W'(2) <= ws);
        tick_left  = ((spacing == SP_W'(1)) || (ph == SP_W'(1))) && (cs >= SUM_W'(2));
        tick_right = (ph == spacing - SP_W'(1)) && (cs + SUM_W'(3) <= ws);

        on  = side_on || bottom_on || center_on ||
              (ctrl.ticks_en && (tick_here || tick_left || tick_right));
        eor = (cs + SUM_W'(1) == ws);
        eof = eor && (rs + SUM_W'(1) == hs);
        ph_inc = {1'b0, ph} + (SP_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.busy)
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                phase_reg <= '0;
            end
            else if (take && empty)
            begin
                col_reg   <= c;
                row_reg   <= r;
                phase_reg <= ph;
            end
            else if (take)
            begin
                if (eor)
                begin
                    col_reg   <= '0;
                    phase_reg <= '0;
                    row_reg   <= eof ? '0 : COL_W'(rs + SUM_W'(1));
                end
                else
                begin
                    col_reg   <= COL_W'(cs + SUM_W'(1));
                    row_reg   <= r;
                    if (spacing != '0)
                        phase_reg <= (ph_inc >= {1'b0, spacing}) ? '0 : ph_inc[SP_W-1:0];
                    else
                        phase_reg <= ph;
                end
            end

            if (take && !empty)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !empty)
        begin
            pix_reg <= on ? PIX_ON : PIX_OFF;
            eor_reg <= eor;
            eof_reg <= eof;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign pixel_value   = pix_reg;
    assign last_in_row   = eor_reg;
    assign last_in_frame = eof_reg;

    a_eof_has_eor: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && eof_reg |-> eor_reg)
        else $error("frame end without row end");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.busy |-> !s_axis_tready)
        else $error("item accepted while spacing is recomputed");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.busy && (width != '0) |-> (SUM_W'(col_reg) < SUM_W'(width)))
        else $error("column counter beyond ruler width");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.busy |-> ((spacing == '0) ? (phase_reg == '0) : (phase_reg < spacing)))
        else $error("tick phase out of range");

endmodule

### test/ohr_raster_checker.sv
// pixel predictor and scoreboard for the heading ruler raster unit
// watches the register, tick and pixel channels; depends on ohr_pkg only
module ohr_raster_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [ohr_pkg::DATA_IN_W-1:0] s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [ohr_pkg::PIX_W-1:0]     m_axis_tdata,
    input  logic                          m_axis_tlast,
    input  logic                          m_axis_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ohr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ohr_pkg::CFG_W-1:0]     cfg_data,
    output int                            mismatch_count,
    output int                            pixels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ohr_pkg::*;

    localparam int BAND      = BAND_HALF_DEF;
    localparam int PRINT_MAX = 200;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             row_end;
        logic             frame_end;
    } ruler_pixel_t;

    ruler_pixel_t expected_pixels[$];
    ruler_pixel_t want;

    logic [CFG_W-1:0]   image_w;
    logic [CFG_W-1:0]   image_h;
    logic [CFG_W-1:0]   ruler_w;
    logic [CFG_W-1:0]   ruler_h;
    logic [PARTS_W-1:0] parts_reg;

    int col_pos;
    int row_pos;
    int tick_pos;
    int tick_gap;
    int bad_count = 0;
    int pixels_seen = 0;

    function automatic int dim_limit(int req, int img);
        int v;
        v = (req < img) ? req : img;
        return (v < MAX_DIM_DEF) ? v : MAX_DIM_DEF;
    endfunction

    function automatic int ruler_cols();
        return dim_limit(int'(ruler_w), int'(image_w));
    endfunction

    function automatic int ruler_rows();
        return dim_limit(int'(ruler_h), int'(image_h));
    endfunction

    function automatic int parts_eff();
        return (parts_reg == '0) ? 2 : int'(parts_reg);
    endfunction

    // any write to a known register restarts the frame with a fresh spacing
    task automatic restart_spacing();
        tick_gap = (ruler_cols() / 2) / parts_eff();
        col_pos  = 0;
        row_pos  = 0;
        tick_pos = 0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (bad_count < PRINT_MAX)
            $display("%0t ns pixel %0d: %s got %0d expected %0d",
                     $time, pixels_seen, what, got, exp_val);
        bad_count++;
    endtask

    task automatic predict_pixel(input logic restart);
        int cols;
        int rows;
        int c;
        int r;
        int d;
        logic lit;
        logic here;
        logic left;
        logic right;
        ruler_pixel_t px;
        cols = ruler_cols();
        rows = ruler_rows();
        if (restart)
        begin
            col_pos  = 0;
            row_pos  = 0;
            tick_pos = 0;
        end
        if (cols == 0 || rows == 0)
            return;
        if (col_pos >= cols || row_pos >= rows)
        begin
            col_pos  = 0;
            row_pos  = 0;
            tick_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        lit = (c <= BAND) || (c >= cols - 1 - BAND) || (r >= rows - 1 - BAND);
        d = c - (cols / 2 - 1);
        if (d >= -(BAND + 1) && d <= BAND + 1)
            lit = 1'b1;
        if (parts_eff() > 1 && tick_gap != 0)
        begin
            here  = (tick_pos == 0) && c >= 1 && c <= cols - 2;
            left  = (tick_gap == 1 || tick_pos == 1) && c >= 2 && c <= cols - 1;
            right = (tick_pos == tick_gap - 1) && c + 1 <= cols - 2;
            if (here || left || right)
                lit = 1'b1;
        end
        px.value     = lit ? PIX_ON : PIX_OFF;
        px.row_end   = (c + 1 == cols);
        px.frame_end = px.row_end && (r + 1 == rows);
        expected_pixels.push_back(px);
        if (px.row_end)
        begin
            col_pos  = 0;
            tick_pos = 0;
            row_pos  = px.frame_end ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
            if (tick_gap != 0)
                tick_pos = (tick_pos + 1 >= tick_gap) ? 0 : tick_pos + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_w   = CFG_W'(RST_IMAGE_WIDTH);
            image_h   = CFG_W'(RST_IMAGE_HEIGHT);
            ruler_w   = CFG_W'(RST_RULER_WIDTH);
            ruler_h   = CFG_W'(RST_RULER_HEIGHT);
            parts_reg = PARTS_W'(RST_PART_COUNT);
            restart_spacing();
            expected_pixels.delete();
        end
        else
        begin
            // output first: a pixel leaving now belongs to an older tick
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("pixel with nothing expected", int'(m_axis_tdata), -1);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata !== want.value)
                        report_mismatch("pixel_value", int'(m_axis_tdata), int'(want.value));
                    if (m_axis_tuser !== want.row_end)
                        report_mismatch("last_in_row", int'(m_axis_tuser), int'(want.row_end));
                    if (m_axis_tlast !== want.frame_end)
                        report_mismatch("last_in_frame", int'(m_axis_tlast),
                                        int'(want.frame_end));
                end
                pixels_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  image_w   = cfg_data;
                    CFG_IMAGE_HEIGHT: image_h   = cfg_data;
                    CFG_RULER_WIDTH:  ruler_w   = cfg_data;
                    CFG_RULER_HEIGHT: ruler_h   = cfg_data;
                    CFG_PART_COUNT:   parts_reg = cfg_data[PARTS_W-1:0];
                    default:          ;
                endcase
                if (cfg_index <= CFG_PART_COUNT)
                    restart_spacing();
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_pixel(s_axis_tdata[0]);
        end
        mismatch_count <= bad_count;
        pixels_pending <= expected_pixels.size();
    end

endmodule

### test/osd_heading_ruler_raster_unit_tb.sv
// testbench top for the heading ruler raster unit: clock, reset, stimulus and verdict
// needs ohr_pkg, osd_heading_ruler_raster_unit and ohr_raster_checker
module osd_heading_ruler_raster_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ohr_pkg::*;

    localparam int ITEM_TARGET  = 1800;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 8;
    localparam int TIMEOUT_NS   = 4_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_IN_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    int mismatch_count;
    int pixels_pending;

    // set by the stimulus, taken by the pixel sink for one long stall
    bit hold_off_req = 1'b0;

    // register values as last written, used only to size each phase
    int cur_image_w = RST_IMAGE_WIDTH;
    int cur_image_h = RST_IMAGE_HEIGHT;
    int cur_ruler_w = RST_RULER_WIDTH;
    int cur_ruler_h = RST_RULER_HEIGHT;

    osd_heading_ruler_raster_unit dut (.*);

    ohr_raster_checker scoreboard (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case the pipeline hangs or drops a pixel
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d pixels still expected", pixels_pending);
        $display("CHECK FAILED");
        $finish;
    end

    // pixel sink: ready pattern in random segments, plus a long hold on request
    initial
    begin : pixel_sink
        int seg;
        int ready_pct;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                seg = $urandom_range(1, 60);
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 50;
                    default: ready_pct = 20;
                endcase
                repeat (seg)
                begin
                    m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
                    @(posedge clk);
                end
            end
        end
    end

    function automatic int span(int req, int img);
        int v;
        v = (req < img) ? req : img;
        return (v < MAX_DIM_DEF) ? v : MAX_DIM_DEF;
    endfunction

    // mostly full-size images so the ruler request decides, sometimes a tight clamp
    function automatic int pick_image_dim();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 40);
            1:       return $urandom_range(0, 2048);
            default: return 2048;
        endcase
    endfunction

    // small rulers keep frames short enough to wrap several times
    function automatic int pick_ruler_dim(int typical_max);
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 2048;
            2, 3:    return $urandom_range(1, 2048);
            default: return $urandom_range(1, typical_max);
        endcase
    endfunction

    function automatic int pick_parts();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 255;
            4:       return $urandom_range(0, 255);
            default: return $urandom_range(3, 12);
        endcase
    endfunction

    // wait until every predicted pixel has left the block
    task automatic drain_results();
        @(posedge clk);
        while (pixels_pending != 0)
            @(posedge clk);
    endtask

    // idle the tick channel and let ticks that make no pixel clear the pipe
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    // one register transaction; valid stays up for back-to-back writes
    task automatic put_reg(input ohr_cfg_idx_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_config(input int iw, input int ih, input int rw, input int rh,
                                input int pc, input logic [4:0] sel);
        quiesce();
        if (sel[CFG_IMAGE_WIDTH])
        begin
            put_reg(CFG_IMAGE_WIDTH, iw);
            cur_image_w = iw;
        end
        if (sel[CFG_IMAGE_HEIGHT])
        begin
            put_reg(CFG_IMAGE_HEIGHT, ih);
            cur_image_h = ih;
        end
        if (sel[CFG_RULER_WIDTH])
        begin
            put_reg(CFG_RULER_WIDTH, rw);
            cur_ruler_w = rw;
        end
        if (sel[CFG_RULER_HEIGHT])
        begin
            put_reg(CFG_RULER_HEIGHT, rh);
            cur_ruler_h = rh;
        end
        if (sel[CFG_PART_COUNT])
            put_reg(CFG_PART_COUNT, pc);
        cfg_valid <= 1'b0;
    endtask

    // pixel ticks in bursts with gaps; restart on the first tick if asked,
    // then only as rare noise that breaks a frame midway
    task automatic send_ticks(input int count, input bit first_restart, input bit pause_mid);
        int burst_left;
        int gap;
        bit restart;
        burst_left = $urandom_range(1, 12);
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
            begin
                // sender waits for the sink to catch up completely
                s_axis_tvalid <= 1'b0;
                drain_results();
            end
            restart = (i == 0) ? first_restart : ($urandom_range(0, 99) == 0);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {{(DATA_IN_W-1){1'b0}}, restart};
            do @(posedge clk); while (!s_axis_tready);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 12);
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 4);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        int counted;
        int phase_no;
        int iw;
        int ih;
        int rw;
        int rh;
        int pc;
        int cols;
        int rows;
        int n;
        logic [4:0] sel;

        counted  = 0;
        phase_no = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: 256 x 32, spacing 64, with a restart mid-row
        send_ticks(4, 1'b1, 1'b0);
        send_ticks(2, 1'b1, 1'b0);

        // empty frame via zero ruler width, then via zero image height
        write_config(2048, 2048, 0, 4, 2, '1);
        send_ticks(2, 1'b0, 1'b0);
        write_config(2048, 0, 16, 4, 2, '1);
        send_ticks(2, 1'b1, 1'b0);

        // narrow 3 x 2 ruler, part count zero means two, zero spacing, frame wrap
        write_config(2048, 2048, 3, 2, 0, '1);
        send_ticks(7, 1'b0, 1'b0);

        // width clamped by the image, single part draws no ticks
        write_config(10, 2048, 2048, 1, 1, '1);
        send_ticks(3, 1'b0, 1'b0);

        // largest sizes and part count
        write_config(2048, 2048, 2048, 2048, 255, '1);
        send_ticks(3, 1'b1, 1'b0);

        // random phases; the first one is fixed so the long stall and the
        // full pause land on a ruler that actually produces pixels
        while (counted < ITEM_TARGET)
        begin
            if (phase_no == 0)
            begin
                iw  = 2048;
                ih  = 2048;
                rw  = 40;
                rh  = 4;
                pc  = 3;
                sel = '1;
            end
            else
            begin
                iw  = pick_image_dim();
                ih  = pick_image_dim();
                rw  = pick_ruler_dim(48);
                rh  = pick_ruler_dim(6);
                pc  = pick_parts();
                sel = 5'($urandom_range(1, 31));
            end
            write_config(iw, ih, rw, rh, pc, sel);

            cols = span(cur_ruler_w, cur_image_w);
            rows = span(cur_ruler_h, cur_image_h);
            if (cols == 0 || rows == 0)
                n = $urandom_range(1, 4);
            else if (phase_no == 0)
                n = 400;
            else if (cols * rows <= 400)
                n = cols * rows * $urandom_range(1, 3) + $urandom_range(0, cols);
            else
                n = $urandom_range(20, 150);
            if (n > 600)
                n = 600;
            // last phase only tops up the item budget
            if (cols != 0 && rows != 0 && n > ITEM_TARGET - counted)
                n = ITEM_TARGET - counted;

            // long sink stall while ticks keep coming, so the input backs up
            if (phase_no == 0 || $urandom_range(0, 7) == 0)
                hold_off_req = 1'b1;
            send_ticks(n, ($urandom_range(0, 3) != 0),
                       (phase_no == 0 || $urandom_range(0, 5) == 0));
            if (cols != 0 && rows != 0)
                counted += n;
            phase_no++;
        end

        quiesce();
        if (mismatch_count == 0 && pixels_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
